>>> design/assert_macros.svh
// Assertion macros shared by the column destripe filter RTL.
// Needs a clk and an active-low rst_n in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication that must hold in the same cycle.
`define CDF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication that must hold in the following cycle.
`define CDF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/cdf_pkg.sv
// Package for the column destripe filter: sizes, config and command types,
// and helper functions. Depends on nothing.
package cdf_pkg;

  localparam int MAX_WIDTH    = 256;
  localparam int MAX_HEIGHT   = 192;
  localparam int WINDOW_REACH = 8;
  localparam int TAPS         = 2 * WINDOW_REACH + 1;
  localparam int STORE_DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W       = $clog2(STORE_DEPTH);
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int ROW_W        = $clog2(MAX_HEIGHT);
  localparam int PIX_W        = 14;
  localparam logic [PIX_W-1:0] PIX_MAX = 14'h3FFF;
  localparam int K_W          = $clog2(TAPS + 1);

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_WIDTH    = 2'd0;
  localparam logic [1:0] REG_HEIGHT   = 2'd1;
  localparam logic [1:0] REG_CONTRAST = 2'd2;
  localparam logic [1:0] REG_VOTECAP  = 2'd3;

  typedef struct packed {
    logic [8:0] width;
    logic [7:0] height;
    logic [9:0] limit;
    logic [4:0] cap;
  } cfg_t;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_READ,
    CMD_NR
  } cmd_kind_t;

  // One word passed from the front to the back through the queue.
  typedef struct packed {
    cmd_kind_t          kind;
    logic               final_load;
    logic [ADDR_W-1:0]  addr;
    logic [COL_W-1:0]   col;
    logic               last;
    logic [PIX_W-1:0]   pixel;
  } cmd_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_RDOUT,
    B_CLR,
    B_TAP,
    B_SUM,
    B_MUL1,
    B_MUL2,
    B_ACC,
    B_DRD,
    B_DLD,
    B_DIT
  } back_state_t;

  // Width in use, clamped to 16..MAX_WIDTH.
  function automatic logic [8:0] used_width_f(input logic [8:0] w);
    logic [8:0] r;
    r = w;
    if (w < 9'd16) r = 9'd16;
    if (w > 9'(MAX_WIDTH)) r = 9'(MAX_WIDTH);
    return r;
  endfunction

  // Height in use, clamped to 1..MAX_HEIGHT.
  function automatic logic [7:0] used_height_f(input logic [7:0] h);
    logic [7:0] r;
    r = h;
    if (h < 8'd1) r = 8'd1;
    if (h > 8'(MAX_HEIGHT)) r = 8'(MAX_HEIGHT);
    return r;
  endfunction

  // ceil(65536 / cnt) for counts of one up to the window size.
  function automatic logic [16:0] recip_f(input logic [4:0] cnt);
    logic [16:0] r;
    case (cnt)
      5'd1:    r = 17'd65536;
      5'd2:    r = 17'd32768;
      5'd3:    r = 17'd21846;
      5'd4:    r = 17'd16384;
      5'd5:    r = 17'd13108;
      5'd6:    r = 17'd10923;
      5'd7:    r = 17'd9363;
      5'd8:    r = 17'd8192;
      5'd9:    r = 17'd7282;
      5'd10:   r = 17'd6554;
      5'd11:   r = 17'd5958;
      5'd12:   r = 17'd5462;
      5'd13:   r = 17'd5042;
      5'd14:   r = 17'd4682;
      5'd15:   r = 17'd4370;
      5'd16:   r = 17'd4096;
      5'd17:   r = 17'd3856;
      default: r = 17'd65536;
    endcase
    return r;
  endfunction

endpackage

>>> design/cdf_ram.sv
// Generic simple dual-port RAM with one write port and a registered read.
// Depends on nothing.
module cdf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/cdf_queue.sv
// Two-deep command queue between the front and the back.
// Depends on cdf_pkg.
module cdf_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  cdf_pkg::cmd_t push_cmd,
  input  logic          pop,
  output cdf_pkg::cmd_t head_cmd,
  output logic          head_valid,
  output logic          full
);

  cdf_pkg::cmd_t entry_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    count_r, count_nxt;

  assign head_cmd   = entry_r[rd_ptr_r];
  assign head_valid = (count_r != 2'd0);
  assign full       = (count_r == 2'd2);

  // Pointer and count update.
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  `include "assert_macros.svh"
  `CDF_ASSERT_IMP(a_no_overflow, full, !push || pop, "queue written while full")
  `CDF_ASSERT_IMP(a_no_underflow, pop, head_valid, "queue read while empty")
  `CDF_ASSERT_NEXT(a_push_only_fills, push && !pop && count_r == 2'd1, full,
    "queue did not fill")

endmodule

>>> design/cdf_front.sv
// Front part: accepts items, tracks load and read positions and the frame
// ready flag, and turns each item into a command word. Depends on cdf_pkg.
module cdf_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  cdf_pkg::cfg_t              cfg,
  input  logic                       geom_clear,
  input  logic                       accept,
  input  logic                       mode,
  input  logic [15:0]                pixel_in,
  output logic                       push,
  output cdf_pkg::cmd_t              push_cmd
);

  logic [8:0]                  used_w;
  logic [7:0]                  used_h;
  logic [cdf_pkg::ADDR_W-1:0]  total;
  logic [cdf_pkg::ADDR_W-1:0]  load_pos_r, load_pos_nxt;
  logic [cdf_pkg::ADDR_W-1:0]  read_pos_r, read_pos_nxt;
  logic [cdf_pkg::COL_W-1:0]   read_col_r, read_col_nxt;
  logic                        ready_r, ready_nxt;
  logic [cdf_pkg::PIX_W-1:0]   sat_pix;

  assign used_w  = cdf_pkg::used_width_f(cfg.width);
  assign used_h  = cdf_pkg::used_height_f(cfg.height);
  assign total   = cdf_pkg::ADDR_W'({7'd0, used_w} * {8'd0, used_h});
  assign sat_pix = (pixel_in > {2'b00, cdf_pkg::PIX_MAX}) ? cdf_pkg::PIX_MAX
                                                          : pixel_in[cdf_pkg::PIX_W-1:0];
  assign push    = accept;

  // Classify the item and advance the positions.
  always_comb begin
    load_pos_nxt        = load_pos_r;
    read_pos_nxt        = read_pos_r;
    read_col_nxt        = read_col_r;
    ready_nxt           = ready_r;
    push_cmd.kind       = cdf_pkg::CMD_NR;
    push_cmd.final_load = 1'b0;
    push_cmd.addr       = read_pos_r;
    push_cmd.col        = read_col_r;
    push_cmd.last       = (read_pos_r == total - 1'b1);
    push_cmd.pixel      = sat_pix;
    if (!mode) begin
      push_cmd.kind = cdf_pkg::CMD_LOAD;
      push_cmd.addr = load_pos_r;
    end else if (ready_r) begin
      push_cmd.kind = cdf_pkg::CMD_READ;
    end
    if (accept) begin
      if (!mode) begin
        if (load_pos_r == '0) begin
          ready_nxt = 1'b0;
        end
        load_pos_nxt = load_pos_r + 1'b1;
        if (load_pos_r + 1'b1 >= total) begin
          push_cmd.final_load = 1'b1;
          ready_nxt           = 1'b1;
          load_pos_nxt        = '0;
          read_pos_nxt        = '0;
          read_col_nxt        = '0;
        end
      end else if (ready_r) begin
        if (read_pos_r + 1'b1 >= total) begin
          read_pos_nxt = '0;
          read_col_nxt = '0;
        end else begin
          read_pos_nxt = read_pos_r + 1'b1;
          read_col_nxt = ({1'b0, read_col_r} == used_w - 1'b1) ? '0 : read_col_r + 1'b1;
        end
      end
    end
    if (geom_clear) begin
      load_pos_nxt = '0;
      read_pos_nxt = '0;
      read_col_nxt = '0;
      ready_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_pos_r <= '0;
      read_pos_r <= '0;
      read_col_r <= '0;
      ready_r    <= 1'b0;
    end else begin
      load_pos_r <= load_pos_nxt;
      read_pos_r <= read_pos_nxt;
      read_col_r <= read_col_nxt;
      ready_r    <= ready_nxt;
    end
  end

endmodule

>>> design/cdf_div.sv
// Iterative signed-by-unsigned divider, one quotient bit per cycle, for the
// column corrections. Depends on nothing.
module cdf_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] dividend,
  input  logic [15:0]        divisor,
  output logic               done,
  output logic [15:0]        quotient
);

  logic        busy_r;
  logic [5:0]  step_r;
  logic        neg_r;
  logic        zero_r;
  logic [15:0] dvs_r;
  logic [16:0] rem_r;
  logic [31:0] quo_r;
  logic [16:0] rem_sh;
  logic [31:0] quo_fix;
  logic        done_r;

  assign rem_sh   = {rem_r[15:0], quo_r[31]};
  assign quo_fix  = neg_r ? (~quo_r + 32'd1) : quo_r;
  assign done     = done_r;
  assign quotient = zero_r ? 16'd0 : quo_fix[15:0];

  // Control: 32 restoring steps after start.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == 6'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: magnitude division, sign applied at the end.
  always_ff @(posedge clk) begin
    if (start) begin
      neg_r  <= dividend[31];
      zero_r <= (divisor == 16'd0);
      dvs_r  <= divisor;
      rem_r  <= '0;
      quo_r  <= dividend[31] ? (~dividend + 32'd1) : dividend;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_r <= rem_sh - {1'b0, dvs_r};
        quo_r <= {quo_r[30:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        quo_r <= {quo_r[30:0], 1'b0};
      end
    end
  end

endmodule

>>> design/cdf_back.sv
// Back part: executes queued commands, owns the frame store and column
// memories, and runs the per-frame vote and correction pass.
// Depends on cdf_pkg, cdf_ram and cdf_div.
module cdf_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cdf_pkg::cfg_t             cfg,
  input  cdf_pkg::cmd_t             head_cmd,
  input  logic                      head_valid,
  output logic                      pop,
  output logic                      out_valid,
  output logic [cdf_pkg::PIX_W-1:0] out_pixel,
  output logic                      out_last,
  output logic                      out_nr
);

  cdf_pkg::back_state_t state_r, state_nxt;

  logic [8:0]                 used_w;
  logic [7:0]                 used_h;
  logic [8:0]                 last_col;
  logic [cdf_pkg::K_W-1:0]    k_r, kd_r;
  logic                       tap_vld_r;
  logic [cdf_pkg::PIX_W-1:0]  center_r;
  logic signed [15:0]         sum_r;
  logic [4:0]                 cnt_r;
  logic [cdf_pkg::COL_W-1:0]  x_r;
  logic [cdf_pkg::ROW_W-1:0]  y_r;
  logic [cdf_pkg::ADDR_W-1:0] row_r;
  logic [cdf_pkg::COL_W-1:0]  col_r;
  logic signed [21:0]         prod1_r;
  logic signed [39:0]         prod2_r;
  logic [4:0]                 votes_r;
  logic [16:0]                recip_r;
  logic                       last_r;
  logic                       out_valid_r, out_last_r, out_nr_r;
  logic [cdf_pkg::PIX_W-1:0]  out_pixel_r;

  // Memory ports.
  logic                       st_we;
  logic [cdf_pkg::ADDR_W-1:0] st_raddr;
  logic [cdf_pkg::PIX_W-1:0]  st_rdata;
  logic                       col_we;
  logic [cdf_pkg::COL_W-1:0]  col_waddr, col_raddr;
  logic [31:0]                dsum_wdata, dsum_rdata;
  logic [15:0]                vsum_wdata, vsum_rdata;
  logic                       corr_we;
  logic [15:0]                corr_rdata;
  logic [cdf_pkg::COL_W-1:0]  corr_raddr;

  // Divider handshake.
  logic        div_start;
  logic        div_done;
  logic [15:0] div_q;

  // Window mirror arithmetic.
  logic signed [10:0] lastw, xd, ma, mb, mbabs, mm;
  logic [cdf_pkg::COL_W-1:0] tap_m;

  // Tap compare and final vote.
  logic signed [15:0] pd, pdabs;
  logic [4:0]         cnt_e, votes;
  logic [5:0]         vote_max;
  logic signed [16:0] rd_sum;
  logic signed [39:0] prod_sh;

  assign used_w   = cdf_pkg::used_width_f(cfg.width);
  assign used_h   = cdf_pkg::used_height_f(cfg.height);
  assign last_col = used_w - 9'd1;

  // Mirrored column of the tap being issued.
  always_comb begin
    lastw = $signed({2'b00, last_col});
    xd    = $signed({3'b000, x_r}) + $signed({{(11-cdf_pkg::K_W){1'b0}}, k_r})
            - 11'sd1 - 11'(cdf_pkg::WINDOW_REACH);
    ma    = (xd < 0) ? -xd : xd;
    mb    = lastw - ma;
    mbabs = (mb < 0) ? -mb : mb;
    mm    = lastw - mbabs;
    if (mm < 0) mm = '0;
    if (mm > lastw) mm = lastw;
    tap_m = mm[cdf_pkg::COL_W-1:0];
  end

  // Delta to the center and its magnitude.
  assign pd    = $signed({2'b00, st_rdata}) - $signed({2'b00, center_r});
  assign pdabs = (pd < 0) ? -pd : pd;

  // Votes from the final count.
  always_comb begin
    cnt_e    = (cnt_r == 5'd0) ? 5'd1 : cnt_r;
    vote_max = {1'b0, cfg.cap} + 6'd1;
    votes    = ({1'b0, cnt_e} < vote_max) ? cnt_e : vote_max[4:0];
  end

  assign prod_sh = prod2_r >>> 16;
  assign rd_sum  = $signed({3'b000, st_rdata}) + $signed({corr_rdata[15], corr_rdata});

  // Next state and memory port control.
  always_comb begin
    state_nxt  = state_r;
    pop        = 1'b0;
    st_we      = 1'b0;
    st_raddr   = row_r + {{(cdf_pkg::ADDR_W-cdf_pkg::COL_W){1'b0}}, tap_m};
    col_we     = 1'b0;
    col_waddr  = x_r;
    col_raddr  = x_r;
    dsum_wdata = dsum_rdata + 32'(prod_sh);
    vsum_wdata = vsum_rdata + {11'd0, votes_r};
    corr_we    = 1'b0;
    corr_raddr = head_cmd.col;
    div_start  = 1'b0;
    case (state_r)
      cdf_pkg::B_IDLE: begin
        st_raddr = head_cmd.addr;
        if (head_valid) begin
          pop = 1'b1;
          case (head_cmd.kind)
            cdf_pkg::CMD_LOAD: begin
              st_we = 1'b1;
              if (head_cmd.final_load) state_nxt = cdf_pkg::B_CLR;
            end
            cdf_pkg::CMD_READ: state_nxt = cdf_pkg::B_RDOUT;
            default:           state_nxt = cdf_pkg::B_IDLE;
          endcase
        end
      end
      cdf_pkg::B_RDOUT: state_nxt = cdf_pkg::B_IDLE;
      cdf_pkg::B_CLR: begin
        col_we     = 1'b1;
        col_waddr  = col_r;
        dsum_wdata = '0;
        vsum_wdata = '0;
        if (col_r == cdf_pkg::COL_W'(cdf_pkg::MAX_WIDTH - 1)) state_nxt = cdf_pkg::B_TAP;
      end
      cdf_pkg::B_TAP: begin
        if (k_r == '0) st_raddr = row_r + {{(cdf_pkg::ADDR_W-cdf_pkg::COL_W){1'b0}}, x_r};
        if (k_r == cdf_pkg::K_W'(cdf_pkg::TAPS)) state_nxt = cdf_pkg::B_SUM;
      end
      cdf_pkg::B_SUM:  state_nxt = cdf_pkg::B_MUL1;
      cdf_pkg::B_MUL1: state_nxt = cdf_pkg::B_MUL2;
      cdf_pkg::B_MUL2: state_nxt = cdf_pkg::B_ACC;
      cdf_pkg::B_ACC: begin
        col_we = 1'b1;
        if ({1'b0, x_r} == last_col) begin
          state_nxt = ({1'b0, y_r} == used_h - 8'd1) ? cdf_pkg::B_DRD : cdf_pkg::B_TAP;
        end else begin
          state_nxt = cdf_pkg::B_TAP;
        end
      end
      cdf_pkg::B_DRD: begin
        col_raddr = col_r;
        state_nxt = cdf_pkg::B_DLD;
      end
      cdf_pkg::B_DLD: begin
        col_raddr = col_r;
        div_start = 1'b1;
        state_nxt = cdf_pkg::B_DIT;
      end
      cdf_pkg::B_DIT: begin
        col_raddr = col_r;
        if (div_done) begin
          corr_we = 1'b1;
          state_nxt = (col_r == cdf_pkg::COL_W'(cdf_pkg::MAX_WIDTH - 1)) ? cdf_pkg::B_IDLE
                                                                        : cdf_pkg::B_DRD;
        end
      end
      default: state_nxt = cdf_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cdf_pkg::B_IDLE;
      out_valid_r <= 1'b0;
      tap_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == cdf_pkg::B_RDOUT) ||
                     (pop && head_cmd.kind == cdf_pkg::CMD_NR);
      tap_vld_r   <= (state_r == cdf_pkg::B_TAP);
    end
  end

  // Datapath registers of the sequencer and the result.
  always_ff @(posedge clk) begin
    kd_r <= k_r;
    if (tap_vld_r) begin
      if (kd_r == '0) begin
        center_r <= st_rdata;
      end else if (pdabs <= $signed({6'd0, cfg.limit})) begin
        sum_r <= sum_r + pd;
        cnt_r <= cnt_r + 5'd1;
      end
    end
    case (state_r)
      cdf_pkg::B_IDLE: begin
        last_r      <= head_cmd.last;
        out_pixel_r <= '0;
        out_last_r  <= 1'b0;
        out_nr_r    <= 1'b1;
        col_r       <= '0;
      end
      cdf_pkg::B_RDOUT: begin
        if (rd_sum < 0) out_pixel_r <= '0;
        else if (rd_sum > $signed({3'b000, cdf_pkg::PIX_MAX})) out_pixel_r <= cdf_pkg::PIX_MAX;
        else out_pixel_r <= rd_sum[cdf_pkg::PIX_W-1:0];
        out_last_r <= last_r;
        out_nr_r   <= 1'b0;
      end
      cdf_pkg::B_CLR: begin
        col_r <= col_r + 1'b1;
        k_r   <= '0;
        x_r   <= '0;
        y_r   <= '0;
        row_r <= '0;
      end
      cdf_pkg::B_TAP: begin
        if (k_r == '0) begin
          sum_r <= '0;
          cnt_r <= '0;
        end
        k_r <= (k_r == cdf_pkg::K_W'(cdf_pkg::TAPS)) ? '0 : k_r + 1'b1;
      end
      cdf_pkg::B_MUL1: begin
        prod1_r <= sum_r * $signed({1'b0, votes});
        votes_r <= votes;
        recip_r <= cdf_pkg::recip_f(cnt_e);
      end
      cdf_pkg::B_MUL2: begin
        prod2_r <= prod1_r * $signed({1'b0, recip_r});
      end
      cdf_pkg::B_ACC: begin
        if ({1'b0, x_r} == last_col) begin
          x_r   <= '0;
          y_r   <= y_r + 1'b1;
          row_r <= row_r + {{(cdf_pkg::ADDR_W-9){1'b0}}, used_w};
        end else begin
          x_r <= x_r + 1'b1;
        end
        col_r <= '0;
      end
      cdf_pkg::B_DIT: begin
        if (div_done) col_r <= col_r + 1'b1;
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_pixel = out_pixel_r;
  assign out_last  = out_last_r;
  assign out_nr    = out_nr_r;

  cdf_ram #(.WIDTH(cdf_pkg::PIX_W), .DEPTH(cdf_pkg::STORE_DEPTH)) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (head_cmd.addr),
    .wdata (head_cmd.pixel),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  cdf_ram #(.WIDTH(32), .DEPTH(cdf_pkg::MAX_WIDTH)) u_dsum (
    .clk   (clk),
    .we    (col_we),
    .waddr (col_waddr),
    .wdata (dsum_wdata),
    .raddr (col_raddr),
    .rdata (dsum_rdata)
  );

  cdf_ram #(.WIDTH(16), .DEPTH(cdf_pkg::MAX_WIDTH)) u_vsum (
    .clk   (clk),
    .we    (col_we),
    .waddr (col_waddr),
    .wdata (vsum_wdata),
    .raddr (col_raddr),
    .rdata (vsum_rdata)
  );

  cdf_ram #(.WIDTH(16), .DEPTH(cdf_pkg::MAX_WIDTH)) u_corr (
    .clk   (clk),
    .we    (corr_we),
    .waddr (col_r),
    .wdata (div_q),
    .raddr (corr_raddr),
    .rdata (corr_rdata)
  );

  cdf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ($signed(dsum_rdata)),
    .divisor  (vsum_rdata),
    .done     (div_done),
    .quotient (div_q)
  );

  `include "assert_macros.svh"
  `CDF_ASSERT_IMP(a_nr_zero, out_valid_r && out_nr_r, out_pixel_r == '0 && !out_last_r,
    "not-ready result carries data")
  `CDF_ASSERT_IMP(a_div_in_phase, div_done, state_r == cdf_pkg::B_DIT,
    "divider finished outside the correction phase")
  `CDF_ASSERT_NEXT(a_read_delivers, state_r == cdf_pkg::B_RDOUT, out_valid_r && !out_nr_r,
    "read produced no result")
  `CDF_ASSERT_IMP(a_store_write_idle, st_we, state_r == cdf_pkg::B_IDLE,
    "frame store written during frame processing")

endmodule

>>> design/column_destripe_filter_core.sv
// Column destripe filter: pixel loads fill a frame store, reads return
// each pixel plus the correction of its column. Results cannot be stalled by
// the receiver: each appears for one cycle under out_valid. Loads and reads
// are run by the back end behind a two-word queue, and busy is the queue's
// full flag, so it rises only while the back end is occupied. The load that
// completes a frame starts the column pass: the sums of all 256 columns are
// cleared, then each pixel takes a center read and 17 window reads on the
// single frame store read port, then two multiplies and the accumulate, then
// each of the 256 columns runs the 32-step divider. Items stay queued during
// that time, and busy rises once the queue holds two of them.
// Depends on cdf_pkg, cdf_front, cdf_queue and cdf_back.
module column_destripe_filter_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_mode,
  input  logic [15:0] in_pixel_in,
  output logic        out_valid,
  output logic [13:0] out_corrected_pixel,
  output logic        out_last_of_frame,
  output logic        out_not_ready,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cdf_pkg::cfg_t cfg_r, cfg_nxt;
  logic          wr_en;
  logic          geom_clear;
  logic          accept;
  logic          push, pop, full, head_valid;
  cdf_pkg::cmd_t push_cmd, head_cmd;

  assign pready     = 1'b1;
  assign wr_en      = psel && penable && pwrite;
  assign geom_clear = wr_en && (paddr[3:2] == cdf_pkg::REG_WIDTH ||
                                paddr[3:2] == cdf_pkg::REG_HEIGHT);
  assign busy       = full;
  assign accept     = start && !full;

  // Register writes.
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (paddr[3:2])
        cdf_pkg::REG_WIDTH:    cfg_nxt.width  = pwdata[8:0];
        cdf_pkg::REG_HEIGHT:   cfg_nxt.height = pwdata[7:0];
        cdf_pkg::REG_CONTRAST: cfg_nxt.limit  = pwdata[9:0];
        cdf_pkg::REG_VOTECAP:  cfg_nxt.cap    = pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width  <= 9'd256;
      cfg_r.height <= 8'd192;
      cfg_r.limit  <= 10'd64;
      cfg_r.cap    <= 5'd16;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Register reads.
  always_comb begin
    case (paddr[3:2])
      cdf_pkg::REG_WIDTH:    prdata = {23'd0, cfg_r.width};
      cdf_pkg::REG_HEIGHT:   prdata = {24'd0, cfg_r.height};
      cdf_pkg::REG_CONTRAST: prdata = {22'd0, cfg_r.limit};
      cdf_pkg::REG_VOTECAP:  prdata = {27'd0, cfg_r.cap};
      default:               prdata = '0;
    endcase
  end

  cdf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .geom_clear (geom_clear),
    .accept     (accept),
    .mode       (in_mode),
    .pixel_in   (in_pixel_in),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  cdf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .head_cmd   (head_cmd),
    .head_valid (head_valid),
    .full       (full)
  );

  cdf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head_cmd   (head_cmd),
    .head_valid (head_valid),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_pixel  (out_corrected_pixel),
    .out_last   (out_last_of_frame),
    .out_nr     (out_not_ready)
  );

endmodule
